// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the buffer cache directory RTL.
// Each macro takes a label, the clock, the reset and the checked terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset
`define CHK_HOLDS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("check failed");

// Check that a condition implies another in the same cycle
`define CHK_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");

// Check that a condition implies another in the next cycle
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");

`endif

// ----- rtl/core/bbc_pkg.sv -----
// Shared types and constants of the block buffer cache directory.
// Used by the slot cells, the release list cells and the top level.
package bbc_pkg;

   // Field widths of the request and response words
   localparam int TAG_W    = 32;
   localparam int SLOT_W   = 6;
   localparam int STATUS_W = 4;
   localparam int COUNT_W  = 8;
   localparam int KIND_W   = 2;

   // Commands
   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   // Address kinds
   localparam logic [KIND_W-1:0] KIND_MAPPED = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ZERO   = 2'd1;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_HIT       = 4'd0;
   localparam logic [STATUS_W-1:0] ST_MISS      = 4'd1;
   localparam logic [STATUS_W-1:0] ST_ZERO      = 4'd2;
   localparam logic [STATUS_W-1:0] ST_UNMAPPED  = 4'd3;
   localparam logic [STATUS_W-1:0] ST_NOBUF     = 4'd4;
   localparam logic [STATUS_W-1:0] ST_SATURATED = 4'd5;
   localparam logic [STATUS_W-1:0] ST_HELD      = 4'd6;
   localparam logic [STATUS_W-1:0] ST_RELEASED  = 4'd7;
   localparam logic [STATUS_W-1:0] ST_UNHELD    = 4'd8;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

   // Operation on one slot cell, the target slot travels beside it
   typedef struct packed {
      logic alloc;
      logic incr;
      logic decr;
   } bbc_slot_op_type;

   // Operation on the release list chain
   typedef struct packed {
      logic push;
      logic pull;
   } bbc_list_op_type;

endpackage

// ----- rtl/core/bbc_slot_cell.sv -----
// One slot of the directory: tags, reference count and resident flag.
// Depends on bbc_pkg for field widths and the slot operation struct.
module bbc_slot_cell #(
   parameter int SW       = 6,
   parameter int CELL_IDX = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  bbc_pkg::bbc_slot_op_type     op,
   input  logic [SW-1:0]                op_slot,
   input  logic [bbc_pkg::TAG_W-1:0]    file_id,
   input  logic [bbc_pkg::TAG_W-1:0]    block_index,
   output logic                         hit,
   output logic [bbc_pkg::COUNT_W-1:0]  ref_count
);
   import bbc_pkg::*;

   logic [TAG_W-1:0]   file_tag_ff, file_tag_in;
   logic [TAG_W-1:0]   index_tag_ff, index_tag_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               resident_ff, resident_in;
   logic               sel;

   // Apply the operation when it targets this slot
   always_comb begin
      sel          = (op_slot == SW'(CELL_IDX));
      file_tag_in  = file_tag_ff;
      index_tag_in = index_tag_ff;
      count_in     = count_ff;
      resident_in  = resident_ff;
      if (sel) begin
         if (op.alloc) begin
            file_tag_in  = file_id;
            index_tag_in = block_index;
            count_in     = COUNT_W'(1);
            resident_in  = 1'b1;
         end else if (op.incr) begin
            count_in = count_ff + 1'b1;
         end else if (op.decr) begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   // Compare the tags against the word under lookup
   assign hit       = resident_ff && (file_tag_ff == file_id) && (index_tag_ff == block_index);
   assign ref_count = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         resident_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         resident_ff <= resident_in;
      end
   end

   // Tags hold no reset, they are read only while resident
   always_ff @(posedge clock) begin
      file_tag_ff  <= file_tag_in;
      index_tag_ff <= index_tag_in;
   end

endmodule

// ----- rtl/core/bbc_list_cell.sv -----
// One position of the release list chain, most recent release at position 0.
// Depends on bbc_pkg for the list operation struct.
module bbc_list_cell #(
   parameter int SW       = 6,
   parameter int CELL_IDX = 0
) (
   input  logic                      clock,
   input  bbc_pkg::bbc_list_op_type  op,
   input  logic [SW-1:0]             op_pos,
   input  logic [SW-1:0]             left_entry,
   input  logic [SW-1:0]             right_entry,
   input  logic [SW-1:0]             key,
   input  logic [SW:0]               list_len,
   output logic [SW-1:0]             entry,
   output logic                      key_hit,
   output logic                      is_tail
);
   import bbc_pkg::*;

   logic [SW-1:0] entry_ff, entry_in;
   logic          in_list;

   // Shift right on a push, close the gap from the right on a pull
   always_comb begin
      entry_in = entry_ff;
      if (op.push) begin
         entry_in = left_entry;
      end else if (op.pull && (SW'(CELL_IDX) >= op_pos)) begin
         entry_in = right_entry;
      end
   end

   // Flag the key slot and the oldest entry
   assign in_list = ((SW+1)'(CELL_IDX) < list_len);
   assign key_hit = in_list && (entry_ff == key);
   assign is_tail = ((SW+1)'(CELL_IDX + 1) == list_len);
   assign entry   = entry_ff;

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ----- rtl/core/block_buffer_cache_lru.sv -----
// Block buffer cache directory: NUM_SLOTS slots with reference counts and a
// least recently released replacement list.
// Request channel (req_*): a get (command 0) looks up file_id/block_index,
// a put (command 1) releases slot_number. Every request yields exactly one
// response word on the rsp_* channel with status, slot, fetch_address and
// evicted; a miss that allocates returns the device block to fetch.
// The tag compare across the slot cells is registered in the lookup state,
// the cells and the release list chain are updated in the execute state; a
// hit on a slot that sits on the release list is first located on the list
// in the execute state, then counted up in a remove state, where the chain
// closes the gap. Requests do not overlap: a new request is taken in the
// cycle the previous response is registered.
// Reset (synchronous, active high) clears all reference counts, resident
// flags, the release list length and the unused slot counter.
// A stalled receiver holds the response register; an idle block still takes
// a request, then holds it and takes no other until the response drains.
`include "assert_macros.svh"

module block_buffer_cache_lru #(
   parameter int NUM_SLOTS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_command,
   input  logic [bbc_pkg::TAG_W-1:0]     req_file_id,
   input  logic [bbc_pkg::TAG_W-1:0]     req_block_index,
   input  logic [bbc_pkg::TAG_W-1:0]     req_block_address,
   input  logic [bbc_pkg::KIND_W-1:0]    req_address_kind,
   input  logic [bbc_pkg::SLOT_W-1:0]    req_slot_number,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bbc_pkg::STATUS_W-1:0]  rsp_status,
   output logic [bbc_pkg::SLOT_W-1:0]    rsp_slot,
   output logic [bbc_pkg::TAG_W-1:0]     rsp_fetch_address,
   output logic                          rsp_evicted
);
   import bbc_pkg::*;

   localparam int SW = $clog2(NUM_SLOTS);
   localparam int XW = ((SW > SLOT_W) ? SW : SLOT_W) + 1;
   localparam logic [SW:0] SLOT_COUNT = (SW+1)'(NUM_SLOTS);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_LOOK   = 2'd1;
   localparam logic [1:0] S_EXEC   = 2'd2;
   localparam logic [1:0] S_REMOVE = 2'd3;

   // Control state
   logic [1:0]          state_ff, state_in;
   logic [SW:0]         len_ff, len_in;
   logic [SW:0]         unused_ff, unused_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Request word held for the duration of the operation
   logic                cmd_ff, cmd_in;
   logic [TAG_W-1:0]    fid_ff, fid_in;
   logic [TAG_W-1:0]    bix_ff, bix_in;
   logic [TAG_W-1:0]    bad_ff, bad_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [SLOT_W-1:0]   sn_ff, sn_in;

   // Lookup results
   logic                hit_any_ff, hit_any_in;
   logic [SW-1:0]       hit_slot_ff, hit_slot_in;
   logic [COUNT_W-1:0]  cnt_ff, cnt_in;
   logic [SW-1:0]       tail_ff, tail_in;
   logic [SW-1:0]       pos_ff, pos_in;

   // Response word
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [TAG_W-1:0]    rsp_fetch_ff, rsp_fetch_in;
   logic                rsp_evicted_ff, rsp_evicted_in;

   // Cell array wiring
   logic [NUM_SLOTS-1:0] hit_vec;
   logic [COUNT_W-1:0]   cell_count [NUM_SLOTS];
   logic [SW-1:0]        list_entry [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] list_key;
   logic [NUM_SLOTS-1:0] list_tail;

   bbc_slot_op_type     slot_op;
   logic [SW-1:0]       slot_sel;
   bbc_list_op_type     list_op;

   // Combinational helpers
   logic                go;
   logic                done;
   logic                respond;
   logic                need_remove;
   logic                evict_go;
   logic                sn_ok;
   logic [SW-1:0]       sn_idx;
   logic [SW-1:0]       hit_enc;
   logic [COUNT_W-1:0]  cnt_mux;
   logic [SW-1:0]       tail_mux;
   logic [SW-1:0]       pos_enc;

   assign sn_idx = SW'(sn_ff);
   assign sn_ok  = (XW'(sn_ff) < XW'(NUM_SLOTS));
   assign go     = !rsp_valid_ff || rsp_ready;

   // Slot cells
   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_slot
      bbc_slot_cell #(.SW(SW), .CELL_IDX(i)) u_slot (
         .clock       (clock),
         .reset       (reset),
         .op          (slot_op),
         .op_slot     (slot_sel),
         .file_id     (fid_ff),
         .block_index (bix_ff),
         .hit         (hit_vec[i]),
         .ref_count   (cell_count[i])
      );
   end

   // Release list chain, each cell fed by its neighbors
   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_list
      logic [SW-1:0] left_w;
      logic [SW-1:0] right_w;
      if (i == 0) begin : g_head
         assign left_w = sn_idx;
      end else begin : g_mid_l
         assign left_w = list_entry[i-1];
      end
      if (i == NUM_SLOTS - 1) begin : g_end
         assign right_w = list_entry[i];
      end else begin : g_mid_r
         assign right_w = list_entry[i+1];
      end
      bbc_list_cell #(.SW(SW), .CELL_IDX(i)) u_list (
         .clock       (clock),
         .op          (list_op),
         .op_pos      (pos_ff),
         .left_entry  (left_w),
         .right_entry (right_w),
         .key         (hit_slot_ff),
         .list_len    (len_ff),
         .entry       (list_entry[i]),
         .key_hit     (list_key[i]),
         .is_tail     (list_tail[i])
      );
   end

   // Encode the hit slot, select its count, read the oldest entry
   always_comb begin
      hit_enc  = '0;
      cnt_mux  = '0;
      tail_mux = '0;
      pos_enc  = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (hit_vec[i]) begin
            hit_enc = hit_enc | SW'(i);
         end
         if ((cmd_ff == CMD_PUT) ? (sn_ok && (sn_idx == SW'(i))) : hit_vec[i]) begin
            cnt_mux = cnt_mux | cell_count[i];
         end
         if (list_tail[i]) begin
            tail_mux = tail_mux | list_entry[i];
         end
         if (list_key[i]) begin
            pos_enc = pos_enc | SW'(i);
         end
      end
   end

   assign need_remove = (state_ff == S_EXEC) && (cmd_ff == CMD_GET) && hit_any_ff
                        && (cnt_ff == '0);

   // Sequence one request through lookup and update
   always_comb begin
      state_in       = state_ff;
      len_in         = len_ff;
      unused_in      = unused_ff;
      hit_any_in     = hit_any_ff;
      hit_slot_in    = hit_slot_ff;
      cnt_in         = cnt_ff;
      tail_in        = tail_ff;
      pos_in         = pos_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_fetch_in   = rsp_fetch_ff;
      rsp_evicted_in = rsp_evicted_ff;
      slot_op        = '0;
      slot_sel       = hit_slot_ff;
      list_op        = '0;
      respond        = 1'b0;
      evict_go       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            hit_any_in  = |hit_vec;
            hit_slot_in = hit_enc;
            cnt_in      = cnt_mux;
            tail_in     = tail_mux;
            state_in    = S_EXEC;
         end
         S_EXEC: begin
            if (go) begin
               respond        = 1'b1;
               rsp_slot_in    = '0;
               rsp_fetch_in   = '0;
               rsp_evicted_in = 1'b0;
               if (cmd_ff == CMD_PUT) begin
                  rsp_slot_in = sn_ff;
                  if (!sn_ok || (cnt_ff == '0)) begin
                     rsp_status_in = ST_UNHELD;
                  end else begin
                     slot_op.decr = 1'b1;
                     slot_sel     = sn_idx;
                     if (cnt_ff == COUNT_W'(1)) begin
                        list_op.push  = 1'b1;
                        len_in        = len_ff + 1'b1;
                        rsp_status_in = ST_RELEASED;
                     end else begin
                        rsp_status_in = ST_HELD;
                     end
                  end
               end else if (hit_any_ff) begin
                  rsp_slot_in = SLOT_W'(hit_slot_ff);
                  if (cnt_ff == COUNT_MAX) begin
                     rsp_status_in = ST_SATURATED;
                  end else if (cnt_ff == '0) begin
                     // locate the slot on the release list first
                     respond  = 1'b0;
                     pos_in   = pos_enc;
                     state_in = S_REMOVE;
                  end else begin
                     slot_op.incr  = 1'b1;
                     rsp_status_in = ST_HIT;
                  end
               end else if (kind_ff == KIND_ZERO) begin
                  rsp_status_in = ST_ZERO;
               end else if (kind_ff != KIND_MAPPED) begin
                  rsp_status_in = ST_UNMAPPED;
               end else if (unused_ff < SLOT_COUNT) begin
                  slot_op.alloc = 1'b1;
                  slot_sel      = SW'(unused_ff);
                  unused_in     = unused_ff + 1'b1;
                  rsp_status_in = ST_MISS;
                  rsp_slot_in   = SLOT_W'(unused_ff);
                  rsp_fetch_in  = bad_ff;
               end else if (len_ff != '0) begin
                  // evict the oldest released slot
                  slot_op.alloc  = 1'b1;
                  slot_sel       = tail_ff;
                  len_in         = len_ff - 1'b1;
                  evict_go       = 1'b1;
                  rsp_status_in  = ST_MISS;
                  rsp_slot_in    = SLOT_W'(tail_ff);
                  rsp_fetch_in   = bad_ff;
                  rsp_evicted_in = 1'b1;
               end else begin
                  rsp_status_in = ST_NOBUF;
               end
            end
         end
         S_REMOVE: begin
            if (go) begin
               respond        = 1'b1;
               slot_op.incr   = 1'b1;
               list_op.pull   = 1'b1;
               len_in         = len_ff - 1'b1;
               rsp_status_in  = ST_HIT;
               rsp_slot_in    = SLOT_W'(hit_slot_ff);
               rsp_fetch_in   = '0;
               rsp_evicted_in = 1'b0;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      done = respond;
      if (done) begin
         state_in = req_valid ? S_LOOK : S_IDLE;
      end
   end

   assign req_ready = (state_ff == S_IDLE) || done;

   // Capture the request word on acceptance
   always_comb begin
      cmd_in  = cmd_ff;
      fid_in  = fid_ff;
      bix_in  = bix_ff;
      bad_in  = bad_ff;
      kind_in = kind_ff;
      sn_in   = sn_ff;
      if (req_valid && req_ready) begin
         cmd_in  = req_command;
         fid_in  = req_file_id;
         bix_in  = req_block_index;
         bad_in  = req_block_address;
         kind_in = req_address_kind;
         sn_in   = req_slot_number;
      end
   end

   // Load the response register, drop it once taken
   assign rsp_valid_in = respond ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         unused_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         unused_ff    <= unused_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      fid_ff         <= fid_in;
      bix_ff         <= bix_in;
      bad_ff         <= bad_in;
      kind_ff        <= kind_in;
      sn_ff          <= sn_in;
      hit_any_ff     <= hit_any_in;
      hit_slot_ff    <= hit_slot_in;
      cnt_ff         <= cnt_in;
      tail_ff        <= tail_in;
      pos_ff         <= pos_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_fetch_ff   <= rsp_fetch_in;
      rsp_evicted_ff <= rsp_evicted_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_fetch_address = rsp_fetch_ff;
   assign rsp_evicted       = rsp_evicted_ff;

   // A block is resident in at most one slot
   `CHK_IMPLIES(a_hit_unique, clock, reset, state_ff == S_LOOK, $onehot0(hit_vec))
   // The release list never outgrows the slot count
   `CHK_HOLDS(a_len_bound, clock, reset, len_ff <= SLOT_COUNT)
   // A slot with count zero sits on the release list exactly once
   `CHK_IMPLIES(a_remove_found, clock, reset, need_remove, $onehot(list_key))
   // An eviction shortens the release list by one
   `CHK_NEXT(a_evict_shrinks, clock, reset, evict_go, len_ff == $past(len_ff) - 1'b1)

endmodule

// ----- test/tb_top.sv -----
// Self-checking bench for block_buffer_cache_lru (the cache directory): it drives get and
// put words, predicts every response word and checks it field by field.
// Depends on bbc_pkg and the block_buffer_cache_lru RTL only.
`timescale 1ns / 1ps

module tb_top;
   import bbc_pkg::*;

   localparam int SLOTS       = 64;
   localparam int QUIET_LIMIT = 2000;
   localparam int MIX_ITEMS   = 520;

   // Kinds the package leaves unnamed
   localparam logic [KIND_W-1:0] KIND_UNMAPPED = 2'd2;
   localparam logic [KIND_W-1:0] KIND_FAILED   = 2'd3;

   typedef struct packed {
      logic                command;
      logic [TAG_W-1:0]    file_id;
      logic [TAG_W-1:0]    block_index;
      logic [TAG_W-1:0]    block_address;
      logic [KIND_W-1:0]   address_kind;
      logic [SLOT_W-1:0]   slot_number;
   } cache_request_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [TAG_W-1:0]    fetch_address;
      logic                evicted;
   } cache_reply_type;

   // Directory shadow: tags, counts and release order, plus the replies still owed
   class directory_scoreboard;
      logic [TAG_W-1:0]   file_tag[SLOTS];
      logic [TAG_W-1:0]   index_tag[SLOTS];
      logic [COUNT_W-1:0] ref_count[SLOTS];
      bit                 resident[SLOTS];
      logic [SLOT_W-1:0]  release_list[$];   // front is the most recently released
      int unsigned        next_unused;
      cache_reply_type    awaited_replies[$];
      int unsigned        mismatches;

      function new();
         foreach (ref_count[s]) begin
            ref_count[s] = '0;
            resident[s]  = 1'b0;
         end
         next_unused = 0;
         mismatches  = 0;
      endfunction

      // Work out the reply to one word and update the shadow state
      function cache_reply_type lookup_outcome(cache_request_type r);
         cache_reply_type o;
         int victim;
         o = '0;
         if (r.command == CMD_PUT) begin
            o.slot = r.slot_number;
            if (int'(r.slot_number) >= SLOTS || ref_count[r.slot_number] == 0) begin
               o.status = ST_UNHELD;
               return o;
            end
            ref_count[r.slot_number]--;
            if (ref_count[r.slot_number] != 0) begin
               o.status = ST_HELD;
               return o;
            end
            if (release_list.size() < SLOTS) release_list.push_front(r.slot_number);
            o.status = ST_RELEASED;
            return o;
         end
         // Full tag compare; a resident match wins whatever the address kind
         for (int s = 0; s < SLOTS; s++) begin
            if (resident[s] && file_tag[s] == r.file_id && index_tag[s] == r.block_index) begin
               o.slot = SLOT_W'(s);
               if (ref_count[s] == COUNT_MAX) begin
                  o.status = ST_SATURATED;
                  return o;
               end
               // Pull a released slot out of the release order
               if (ref_count[s] == 0) begin
                  for (int p = 0; p < release_list.size(); p++) begin
                     if (release_list[p] == SLOT_W'(s)) begin
                        release_list.delete(p);
                        break;
                     end
                  end
               end
               ref_count[s]++;
               o.status = ST_HIT;
               return o;
            end
         end
         if (r.address_kind == KIND_ZERO) begin
            o.status = ST_ZERO;
            return o;
         end
         if (r.address_kind != KIND_MAPPED) begin
            o.status = ST_UNMAPPED;
            return o;
         end
         // Take a never-used slot first, else evict the oldest release
         if (next_unused < SLOTS) begin
            victim = int'(next_unused);
            next_unused++;
         end else if (release_list.size() != 0) begin
            victim    = int'(release_list.pop_back());
            o.evicted = 1'b1;
         end else begin
            o.status = ST_NOBUF;
            return o;
         end
         file_tag[victim]  = r.file_id;
         index_tag[victim] = r.block_index;
         ref_count[victim] = COUNT_W'(1);
         resident[victim]  = 1'b1;
         o.status        = ST_MISS;
         o.slot          = SLOT_W'(victim);
         o.fetch_address = r.block_address;
         return o;
      endfunction

      function void note_request(cache_request_type r);
         awaited_replies.push_back(lookup_outcome(r));
      endfunction

      function void check_response(cache_reply_type got);
         cache_reply_type want;
         if (awaited_replies.size() == 0) begin
            $error("response word with nothing awaited: rsp_status %0d rsp_slot %0d",
                   got.status, got.slot);
            mismatches++;
            return;
         end
         want = awaited_replies.pop_front();
         if (got.status !== want.status) begin
            $error("rsp_status: expected %0d, actual %0d", want.status, got.status);
            mismatches++;
         end
         if (got.slot !== want.slot) begin
            $error("rsp_slot: expected %0d, actual %0d", want.slot, got.slot);
            mismatches++;
         end
         if (got.fetch_address !== want.fetch_address) begin
            $error("rsp_fetch_address: expected %h, actual %h",
                   want.fetch_address, got.fetch_address);
            mismatches++;
         end
         if (got.evicted !== want.evicted) begin
            $error("rsp_evicted: expected %0d, actual %0d", want.evicted, got.evicted);
            mismatches++;
         end
      endfunction

      // Pick a slot whose count is above zero, or -1 when none is held
      function int pick_held_slot();
         int held[$];
         for (int s = 0; s < SLOTS; s++) if (ref_count[s] != 0) held.push_back(s);
         if (held.size() == 0) return -1;
         return held[$urandom_range(0, held.size() - 1)];
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_command = CMD_GET;
   logic [TAG_W-1:0]    req_file_id = '0;
   logic [TAG_W-1:0]    req_block_index = '0;
   logic [TAG_W-1:0]    req_block_address = '0;
   logic [KIND_W-1:0]   req_address_kind = KIND_MAPPED;
   logic [SLOT_W-1:0]   req_slot_number = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_slot;
   logic [TAG_W-1:0]    rsp_fetch_address;
   logic                rsp_evicted;

   directory_scoreboard sb = new();
   logic [2*TAG_W-1:0]  key_pool[$];   // recent {file_id, block_index} pairs
   bit                  idling_on = 1'b1;
   int                  quiet_cycles = 0;

   block_buffer_cache_lru #(.NUM_SLOTS(SLOTS)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_file_id       (req_file_id),
      .req_block_index   (req_block_index),
      .req_block_address (req_block_address),
      .req_address_kind  (req_address_kind),
      .req_slot_number   (req_slot_number),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_slot          (rsp_slot),
      .rsp_fetch_address (rsp_fetch_address),
      .rsp_evicted       (rsp_evicted)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic cache_request_type make_get(logic [TAG_W-1:0] fid,
                                                  logic [TAG_W-1:0] bix,
                                                  logic [TAG_W-1:0] bad,
                                                  logic [KIND_W-1:0] kind);
      cache_request_type r;
      r.command       = CMD_GET;
      r.file_id       = fid;
      r.block_index   = bix;
      r.block_address = bad;
      r.address_kind  = kind;
      r.slot_number   = SLOT_W'($urandom_range(0, SLOTS - 1));
      return r;
   endfunction

   function automatic cache_request_type make_put(logic [SLOT_W-1:0] sn);
      cache_request_type r;
      r.command       = CMD_PUT;
      r.file_id       = $urandom;
      r.block_index   = $urandom;
      r.block_address = $urandom;
      r.address_kind  = KIND_W'($urandom_range(0, 3));
      r.slot_number   = sn;
      return r;
   endfunction

   // Get on a recent key, or on a fresh key that joins the pool
   function automatic cache_request_type random_get(bit reuse);
      cache_request_type r;
      int pick;
      r = make_get($urandom, $urandom, $urandom, KIND_W'($urandom_range(0, 3)));
      if (reuse && key_pool.size() != 0) begin
         pick = $urandom_range(0, key_pool.size() - 1);
         {r.file_id, r.block_index} = key_pool[pick];
         if ($urandom_range(0, 1) == 0) r.address_kind = KIND_MAPPED;
         return r;
      end
      case ($urandom_range(0, 5))
         0: r.file_id = '0;
         1: r.file_id = '1;
         2: r.file_id = $urandom_range(0, 7);
         default: ;
      endcase
      if ($urandom_range(0, 2) == 0) r.block_index = $urandom_range(0, 15);
      if ($urandom_range(0, 3) != 0) r.address_kind = KIND_MAPPED;
      key_pool.push_back({r.file_id, r.block_index});
      if (key_pool.size() > 96) void'(key_pool.pop_front());
      return r;
   endfunction

   // Mostly release a held slot, sometimes any slot
   function automatic cache_request_type random_put();
      int held;
      held = sb.pick_held_slot();
      if (held >= 0 && $urandom_range(0, 7) != 0) return make_put(SLOT_W'(held));
      return make_put(SLOT_W'($urandom_range(0, SLOTS - 1)));
   endfunction

   // Drive one word, hold it until taken, then record it for prediction
   task automatic send_request(input cache_request_type r);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_command       <= r.command;
      req_file_id       <= r.file_id;
      req_block_index   <= r.block_index;
      req_block_address <= r.block_address;
      req_address_kind  <= r.address_kind;
      req_slot_number   <= r.slot_number;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
   endtask

   // Stall the response side in short random bursts
   initial begin : rsp_stall
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left == 0 && idling_on && $urandom_range(0, 4) == 0)
            stall_left = $urandom_range(1, 3);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Check every response word taken
   always @(posedge clock) begin : rsp_monitor
      cache_reply_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.status        = rsp_status;
         got.slot          = rsp_slot;
         got.fetch_address = rsp_fetch_address;
         got.evicted       = rsp_evicted;
         sb.check_response(got);
      end
   end

   // Count cycles in which neither channel moves a word
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      cache_request_type item;
      int extra;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty puts, field extremes, hit before translation, kinds,
      // file-only match, held and released puts, hits off the release list
      send_request(make_put('0));
      send_request(make_put('1));
      send_request(make_get('0, '0, '0, KIND_MAPPED));
      send_request(make_get('1, '1, '1, KIND_MAPPED));
      send_request(make_get('0, '0, 32'h0000_BEEF, KIND_UNMAPPED));
      send_request(make_get(32'd5, 32'd5, 32'h5555_5555, KIND_ZERO));
      send_request(make_get(32'd5, 32'd5, 32'hAAAA_AAAA, KIND_UNMAPPED));
      send_request(make_get(32'd5, 32'd5, 32'h1234_5678, KIND_FAILED));
      send_request(make_get('1, '0, 32'hAAAA_AAAA, KIND_MAPPED));
      send_request(make_get('0, '1, 32'h5555_5555, KIND_MAPPED));
      send_request(make_put(6'd0));
      send_request(make_put(6'd0));
      send_request(make_put(6'd0));
      send_request(make_put(6'd1));
      send_request(make_put(6'd2));
      send_request(make_put(6'd3));
      send_request(make_get('0, '0, '1, KIND_ZERO));
      send_request(make_get('1, '0, '0, KIND_UNMAPPED));
      send_request(make_put(6'h2A));
      send_request(make_put(6'h15));

      // Drive one key up to the count ceiling and past it
      item = random_get(1'b0);
      item.address_kind = KIND_MAPPED;
      send_request(item);
      repeat (257) begin
         item.block_address = $urandom;
         item.address_kind  = KIND_W'($urandom_range(0, 3));
         item.slot_number   = SLOT_W'($urandom_range(0, SLOTS - 1));
         send_request(item);
      end

      // Fill every slot with held blocks, then ask for more with nothing to evict
      extra = 0;
      while (extra < 3) begin
         if (sb.next_unused == SLOTS && sb.release_list.size() == 0) extra++;
         item = random_get(1'b0);
         item.address_kind = KIND_MAPPED;
         send_request(item);
      end
      repeat (40) send_request(random_put());

      // Random mix of gets and puts; the tail runs without idling
      for (int n = 0; n < MIX_ITEMS; n++) begin
         if (n % 40 == 0) idling_on = (n < MIX_ITEMS - 100) && ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 99) < 55) send_request(random_get($urandom_range(0, 9) < 6));
         else send_request(random_put());
      end
      req_valid <= 1'b0;

      // Drain the owed replies, then allow a few cycles for stray words
      while (sb.awaited_replies.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.awaited_replies.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
